// ===== sv/drs_pkg.sv =====
// Shared constants and types for the decimal radix sorter.
`default_nettype none
package drs_pkg;
  localparam int VAL_W         = 31;
  localparam int RADIX         = 10;
  localparam int DIG_W         = 4;
  localparam int MAX_ITEMS_DEF = 64;
  // reciprocal of ten, exact for 32-bit dividends with a 35-bit shift
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
  localparam int RECIP_SH = 35;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] quot;
  } drs_entry_t;
endpackage
`default_nettype wire

// ===== sv/decimal_radix_sorter.sv =====
// Top level of the base-10 LSD radix sorter with ping-pong element memories.
// Usage:
//  Input channel (valid/stall, value/last): each transaction stores one value;
//  values past MAX_ITEMS in one set are dropped. A transaction with last set
//  ends the set and starts the sort; stall stays high until the sorted run
//  has been handed to the output register.
//  Output channel (res_valid/res_stall, sorted_value/final_res): the set comes
//  out in ascending order, final_res set on the largest value.
//  Timing: loading accepts one value per cycle. Each decimal pass clears the
//  digit counts, counts every stored value, forms prefix sums and scatters the
//  values into the other memory, paced by the one-read-port element memories
//  and the registered divide-by-ten unit; passes run once per digit of the
//  largest value (up to ten). Emitting waits for each result to be taken.
//  A stall on the output holds the result register and pauses emission; the
//  next set may load while the last result still waits.
//  Reset (rst, synchronous) empties the set and the output register; memory
//  contents are not cleared.
`default_nettype none
module decimal_radix_sorter import drs_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid,
  output logic                  stall,
  input  wire logic [VAL_W-1:0] value,
  input  wire logic             last,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output logic      [VAL_W-1:0] sorted_value,
  output logic                  final_res
);
  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_CLR, S_CRD, S_CWT, S_CDO, S_PFX,
    S_SRD, S_SWT, S_SDO, S_LQ1, S_LQ2, S_ERD, S_ELD
  } state_t;

  state_t           state;
  logic [CW-1:0]    count;
  logic [CW-1:0]    total;
  logic [VAL_W-1:0] lq;
  logic [IW-1:0]    idx;
  logic [DIG_W-1:0] dg;
  logic [CW-1:0]    acc;
  logic             src;
  logic [CW-1:0]    counts [RADIX];

  drs_entry_t mem0 [MAX_ITEMS];
  drs_entry_t mem1 [MAX_ITEMS];
  drs_entry_t rd0, rd1, rd;

  logic             we;
  logic [IW-1:0]    waddr;
  drs_entry_t       wdata;
  logic             wsel;
  logic [VAL_W-1:0] div_in, div_q;
  logic [DIG_W-1:0] div_r;
  logic             in_acc, out_acc;
  logic [CW-1:0]    pos_c;

  assign in_acc  = valid && !stall;
  assign out_acc = res_valid && !res_stall;
  assign stall   = (state != S_IDLE);
  assign rd      = src ? rd1 : rd0;
  assign div_in  = (state == S_LQ1) ? lq : rd.quot;
  assign pos_c   = counts[div_r] - CW'(1);

  drs_div10 u_div (.clk(clk), .num(div_in), .quot(div_q), .rem(div_r));

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wsel  = src;
    wdata = '{value: value, quot: value};
    if (state == S_IDLE && in_acc && count < CW'(MAX_ITEMS)) begin
      we    = 1'b1;
      waddr = count[IW-1:0];
    end else if (state == S_SDO) begin
      we    = 1'b1;
      waddr = pos_c[IW-1:0];
      wsel  = ~src;
      wdata = '{value: rd.value, quot: div_q};
    end
  end

  always_ff @(posedge clk) begin
    if (we && !wsel) mem0[waddr] <= wdata;
    if (we && wsel)  mem1[waddr] <= wdata;
    rd0 <= mem0[idx];
    rd1 <= mem1[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      lq        <= '0;
      idx       <= '0;
      dg        <= '0;
      acc       <= '0;
      src       <= 1'b0;
      res_valid <= 1'b0;
      for (int k = 0; k < RADIX; k++) counts[k] <= '0;
    end else begin
      if (out_acc) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (count < CW'(MAX_ITEMS)) begin
              count <= count + CW'(1);
              if (value > lq) lq <= value;
            end
            if (last) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          total <= count;
          idx   <= '0;
          state <= (lq == '0) ? S_ERD : S_CLR;
        end
        S_CLR: begin
          for (int k = 0; k < RADIX; k++) counts[k] <= '0;
          idx   <= '0;
          state <= S_CRD;
        end
        S_CRD: state <= S_CWT;
        S_CWT: state <= S_CDO;
        S_CDO: begin
          counts[div_r] <= counts[div_r] + CW'(1);
          if (CW'(idx) == total - CW'(1)) begin
            dg    <= '0;
            acc   <= '0;
            state <= S_PFX;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_CRD;
          end
        end
        S_PFX: begin
          acc        <= acc + counts[dg];
          counts[dg] <= acc + counts[dg];
          if (dg == DIG_W'(RADIX - 1)) begin
            idx   <= IW'(total - CW'(1));
            state <= S_SRD;
          end else begin
            dg <= dg + DIG_W'(1);
          end
        end
        S_SRD: state <= S_SWT;
        S_SWT: state <= S_SDO;
        S_SDO: begin
          counts[div_r] <= pos_c;
          if (idx == '0) begin
            state <= S_LQ1;
          end else begin
            idx   <= idx - IW'(1);
            state <= S_SRD;
          end
        end
        S_LQ1: state <= S_LQ2;
        S_LQ2: begin
          lq  <= div_q;
          src <= ~src;
          idx <= '0;
          state <= (div_q == '0) ? S_ERD : S_CLR;
        end
        S_ERD: begin
          if (!res_valid) state <= S_ELD;
        end
        S_ELD: begin
          res_valid    <= 1'b1;
          sorted_value <= rd.value;
          final_res    <= (CW'(idx) == total - CW'(1));
          if (CW'(idx) == total - CW'(1)) begin
            count <= '0;
            lq    <= '0;
            state <= S_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_ERD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/drs_div10.sv =====
// Registered divide-by-ten unit: quotient and remainder appear in the cycle after the operand.
`default_nettype none
module drs_div10 import drs_pkg::*; (
  input  wire logic             clk,
  input  wire logic [VAL_W-1:0] num,
  output logic      [VAL_W-1:0] quot,
  output logic      [DIG_W-1:0] rem
);
  logic [VAL_W-1:0]    num_r;
  logic [VAL_W+31:0]   prod;
  logic [VAL_W-1:0]    q10;

  always_ff @(posedge clk) begin
    num_r <= num;
    prod  <= {32'd0, num} * {{VAL_W{1'b0}}, RECIP10};
  end

  assign quot = VAL_W'(prod >> RECIP_SH);
  assign q10  = (quot << 3) + (quot << 1);
  always_comb begin
    logic [VAL_W-1:0] diff;
    diff = num_r - q10;
    rem  = diff[DIG_W-1:0];
  end
endmodule
`default_nettype wire

// ===== sv/drs_checker.sv =====
// Port-level checker for the decimal radix sorter, bound to the top level.
`default_nettype none
module drs_checker import drs_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             valid,
  input wire logic             stall,
  input wire logic             last,
  input wire logic             res_valid,
  input wire logic             res_stall,
  input wire logic [VAL_W-1:0] sorted_value,
  input wire logic             final_res
);
  // a held result transaction stays up and unchanged
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(sorted_value) && $stable(final_res))
    else $error("result dropped or changed while stalled");

  // the sort locks out input right after the closing transaction
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    valid && !stall && last |=> stall)
    else $error("input open after last");

  // nothing follows the end of a sorted run directly
  a_final_gap: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && final_res |=> !res_valid)
    else $error("result right after final");

  // no result while a set is still loading from empty output
  a_no_res_load: assert property (@(posedge clk) disable iff (rst)
    !res_valid && !stall |=> !res_valid)
    else $error("result appeared during load");
endmodule

bind decimal_radix_sorter drs_checker u_drs_checker (
  .clk(clk), .rst(rst), .valid(valid), .stall(stall), .last(last),
  .res_valid(res_valid), .res_stall(res_stall),
  .sorted_value(sorted_value), .final_res(final_res)
);
`default_nettype wire

// ===== tb/tb_decimal_radix_sorter.sv =====
// Testbench for the decimal radix sorter: directed and random sets, sorted-order scoreboard.
`timescale 1ns / 1ps
module tb_decimal_radix_sorter import drs_pkg::*; ();

  localparam int SET_CAP = MAX_ITEMS_DEF;

  class sort_scoreboard;
    logic [VAL_W-1:0] pending_set[$];
    logic [VAL_W-1:0] expected_vals[$];
    bit               expected_fin[$];
    int               mismatches;
    int               results_seen;
    int               sets_sorted;

    // radix sort by decimal digit, same stable scatter as the block
    function void sort_pending();
      logic [VAL_W-1:0] src[$];
      logic [VAL_W-1:0] dst[SET_CAP];
      int               cnt[RADIX];
      logic [63:0]      place;
      logic [VAL_W-1:0] top;
      int               n;
      int               d;
      src = pending_set;
      n = src.size();
      top = 0;
      foreach (src[i]) if (src[i] > top) top = src[i];
      place = 1;
      while ((64'(top) / place) > 0) begin
        for (int k = 0; k < RADIX; k++) cnt[k] = 0;
        for (int i = 0; i < n; i++) cnt[int'((64'(src[i]) / place) % RADIX)]++;
        for (int k = 1; k < RADIX; k++) cnt[k] += cnt[k-1];
        for (int i = n - 1; i >= 0; i--) begin
          d = int'((64'(src[i]) / place) % RADIX);
          cnt[d]--;
          dst[cnt[d]] = src[i];
        end
        for (int i = 0; i < n; i++) src[i] = dst[i];
        place = place * 64'(RADIX);
      end
      for (int i = 0; i < n; i++) begin
        expected_vals.push_back(src[i]);
        expected_fin.push_back(i == n - 1);
      end
      pending_set.delete();
      sets_sorted++;
    endfunction

    function void note_input(logic [VAL_W-1:0] v, bit lst);
      if (pending_set.size() < SET_CAP) pending_set.push_back(v);
      if (lst) sort_pending();
    endfunction

    function void check_result(logic [VAL_W-1:0] v, bit fin);
      logic [VAL_W-1:0] ev;
      bit               ef;
      results_seen++;
      if (expected_vals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d final=%0b", v, fin);
        return;
      end
      ev = expected_vals.pop_front();
      ef = expected_fin.pop_front();
      if (ev !== v || ef !== fin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%0d final=%0b, got value=%0d final=%0b",
                   ev, ef, v, fin);
      end
    endfunction
  endclass

  logic             clk = 0;
  logic             rst = 1;
  logic             valid = 0;
  logic             stall;
  logic [VAL_W-1:0] value = '0;
  logic             last = 0;
  logic             res_valid;
  logic             res_stall = 0;
  logic [VAL_W-1:0] sorted_value;
  logic             final_res;

  int send_idle_pct = 12;
  int recv_idle_pct = 72;
  sort_scoreboard sb;

  always #2 clk = ~clk;

  decimal_radix_sorter dut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .value(value), .last(last),
    .res_valid(res_valid), .res_stall(res_stall), .sorted_value(sorted_value),
    .final_res(final_res)
  );

  // receiver: random stall, check on accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_result(sorted_value, final_res);
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // one transaction, with a random gap before it; valid stays up afterwards
  task automatic send_item(logic [VAL_W-1:0] v, bit lst);
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 0;
      @(posedge clk);
    end
    valid <= 1;
    value <= v;
    last <= lst;
    @(posedge clk);
    while (stall) @(posedge clk);
    sb.note_input(v, lst);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return VAL_W'($urandom_range(9));
      1: return VAL_W'($urandom_range(999));
      2: return VAL_W'($urandom_range(99999));
      3: return VAL_W'($urandom);
      4: return VAL_W'(32'h7FFF_FFFF - $urandom_range(20));
      default: return VAL_W'($urandom_range(1000000000, 0));
    endcase
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_item(rand_value(), i == n - 1);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    valid <= 0;
    @(posedge clk);
    while (sb.expected_vals.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    #40_000_000;
    $display("tb_decimal_radix_sorter NOT OK");
    $finish;
  end

  initial begin
    int sent;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: single values, zeros, extremes, ties, full store with overflow
    send_item(0, 1);
    send_item(31'h7FFF_FFFF, 1);
    send_item(5, 0); send_item(5, 0); send_item(0, 0); send_item(3, 1);
    send_item(31'h7FFF_FFFF, 0); send_item(0, 0); send_item(1000000000, 0);
    send_item(31'h2AAA_AAAA, 0); send_item(31'h5555_5555, 1);
    for (int i = 0; i < SET_CAP + 3; i++)
      send_item((i == SET_CAP + 2) ? 31'h7FFF_FFFF : rand_value(), i == SET_CAP + 2);
    // pause until every expected result is out
    wait_drained();

    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 72; recv_idle_pct = 12; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      while (sent < (ph + 1) * 80) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(SET_CAP + 2, 40) : $urandom_range(12, 1);
        send_set(n);
        sent += n;
      end
      wait_drained();
    end
    repeat (50) @(posedge clk);

    $display("covered %0d sorted sets, %0d results checked, idle mixes both ways",
             sb.sets_sorted, sb.results_seen);
    if (sb.mismatches == 0 && sb.expected_vals.size() == 0)
      $display("tb_decimal_radix_sorter OK");
    else
      $display("tb_decimal_radix_sorter NOT OK");
    $finish;
  end
endmodule

// ===== files.f =====
sv/drs_pkg.sv
sv/drs_div10.sv
sv/decimal_radix_sorter.sv
sv/drs_checker.sv
tb/tb_decimal_radix_sorter.sv
